// ===== hw/rtl/vnu_pkg.sv =====
// Package for the 3D vector normalization unit: word types, pipeline sizing
// constants and the single-step functions of the square root and divider.
// No dependencies.
package vnu_pkg;

	typedef struct packed {
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] unit_x;
		logic signed [31:0] unit_y;
		logic signed [31:0] unit_z;
		logic        [31:0] magnitude;
		logic               zero_vector;
	} out_word_t;

	localparam int SQRT_STEPS     = 32;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
	localparam int DIV_STEPS      = 31;
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_acc_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] quo;
	} div_acc_t;

	function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] bits);
		sqrt_acc_t   res;
		logic [34:0] shifted;
		logic [34:0] trial;
		shifted = {acc.rem[32:0], bits};
		trial   = {1'b0, acc.root, 2'b01};
		if (shifted >= trial) begin
			res.rem  = shifted - trial;
			res.root = {acc.root[30:0], 1'b1};
		end else begin
			res.rem  = shifted;
			res.root = {acc.root[30:0], 1'b0};
		end
		return res;
	endfunction

	function automatic div_acc_t div_step(div_acc_t acc, logic bit_in, logic [31:0] divisor);
		div_acc_t    res;
		logic [32:0] shifted;
		shifted = {acc.rem, bit_in};
		if (shifted >= {1'b0, divisor}) begin
			res.rem = 32'(shifted - {1'b0, divisor});
			res.quo = {acc.quo[29:0], 1'b1};
		end else begin
			res.rem = shifted[31:0];
			res.quo = {acc.quo[29:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/vector3_normalize_unit.sv =====
// Top level of the 3D vector normalization unit: front stages, square root,
// three dividers and the output register. Depends on vnu_pkg, vnu_sqrt, vnu_div.
//
//   channel | handshake            | word
//   vec     | vec_valid, vec_ready | vnu_pkg::in_word_t
//   res     | res_valid, res_ready | vnu_pkg::out_word_t
//
// One word enters per cycle while the output is not stalled; a result word passes
// through the four front stages, the two-bits-per-stage square root and divider
// pipelines and the output register after its input word is accepted.
// Reset clears all valid bits and the output register's valid flag.
// When the output word is not taken the whole pipeline holds; vec_ready is low.
module vector3_normalize_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_ready,
	input  vnu_pkg::in_word_t  vec,
	output logic               res_valid,
	input  logic               res_ready,
	output vnu_pkg::out_word_t res
);

	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [2:0]  sign;
		logic [4:0]  half;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
	} sb_sqrt_t;

	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [2:0]  sign;
		logic [31:0] mag;
	} sb_div_t;

	function automatic logic [31:0] abs32(logic [31:0] v);
		return v[31] ? 32'(~v + 32'd1) : v;
	endfunction

	function automatic logic [6:0] lzc64(logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(63 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [31:0] signed_unit(logic [30:0] q, logic neg, logic zero);
		logic [31:0] m;
		m = (q > vnu_pkg::ONE_Q30) ? {1'b0, vnu_pkg::ONE_Q30} : {1'b0, q};
		if (zero) begin
			return '0;
		end
		return neg ? 32'(~m + 32'd1) : m;
	endfunction

	logic adv;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] ax_s1, ay_s1, az_s1;
	logic [2:0]  sign_s1, sign_s2, sign_s3, sign_s4;
	logic [31:0] ax_s2, ay_s2, az_s2, ax_s3, ay_s3, az_s3, ax_s4, ay_s4, az_s4;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [63:0] sum_s3, sum_s4;
	logic [6:0]  lz_s3;
	logic        zero_s4;
	logic [4:0]  half_s4;

	sb_sqrt_t    sb_sqrt_in;
	logic [63:0] rad_in;
	sb_sqrt_t    sbq_s [vnu_pkg::SQRT_STAGES];
	logic [31:0] root;
	sb_div_t     sb_div_in;
	sb_div_t     sbd_s [vnu_pkg::DIV_STAGES];
	logic [30:0] qx, qy, qz;

	logic               res_valid_q;
	vnu_pkg::out_word_t res_q;

	assign adv       = ~res_valid_q | res_ready;
	assign vec_ready = adv;
	assign lz_s3     = lzc64(sum_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= abs32(vec.comp_x);
			ay_s1   <= abs32(vec.comp_y);
			az_s1   <= abs32(vec.comp_z);
			sign_s1 <= {vec.comp_x[31], vec.comp_y[31], vec.comp_z[31]};
			sx_s2   <= ax_s1 * ax_s1;
			sy_s2   <= ay_s1 * ay_s1;
			sz_s2   <= az_s1 * az_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			az_s2   <= az_s1;
			sign_s2 <= sign_s1;
			sum_s3  <= sx_s2 + sy_s2 + sz_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			az_s3   <= az_s2;
			sign_s3 <= sign_s2;
			sum_s4  <= sum_s3;
			zero_s4 <= (sum_s3 == 64'd0);
			half_s4 <= lz_s3[5:1];
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			az_s4   <= az_s3;
			sign_s4 <= sign_s3;
		end
	end

	always_comb begin
		rad_in           = sum_s4 << {half_s4, 1'b0};
		sb_sqrt_in.valid = v_s4;
		sb_sqrt_in.zero  = zero_s4;
		sb_sqrt_in.sign  = sign_s4;
		sb_sqrt_in.half  = half_s4;
		sb_sqrt_in.tx    = ax_s4 << half_s4;
		sb_sqrt_in.ty    = ay_s4 << half_s4;
		sb_sqrt_in.tz    = az_s4 << half_s4;
	end

	vnu_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (rad_in),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vnu_pkg::SQRT_STAGES; i++) begin
				sbq_s[i].valid <= 1'b0;
			end
		end else if (adv) begin
			sbq_s[0] <= sb_sqrt_in;
			for (int i = 1; i < vnu_pkg::SQRT_STAGES; i++) begin
				sbq_s[i] <= sbq_s[i-1];
			end
		end
	end

	always_comb begin
		sb_div_in.valid = sbq_s[vnu_pkg::SQRT_STAGES-1].valid;
		sb_div_in.zero  = sbq_s[vnu_pkg::SQRT_STAGES-1].zero;
		sb_div_in.sign  = sbq_s[vnu_pkg::SQRT_STAGES-1].sign;
		sb_div_in.mag   = root >> sbq_s[vnu_pkg::SQRT_STAGES-1].half;
	end

	vnu_div u_div_x (
		.clk      (clk),
		.en       (adv),
		.t        (sbq_s[vnu_pkg::SQRT_STAGES-1].tx),
		.divisor  (root),
		.quotient (qx)
	);

	vnu_div u_div_y (
		.clk      (clk),
		.en       (adv),
		.t        (sbq_s[vnu_pkg::SQRT_STAGES-1].ty),
		.divisor  (root),
		.quotient (qy)
	);

	vnu_div u_div_z (
		.clk      (clk),
		.en       (adv),
		.t        (sbq_s[vnu_pkg::SQRT_STAGES-1].tz),
		.divisor  (root),
		.quotient (qz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vnu_pkg::DIV_STAGES; i++) begin
				sbd_s[i].valid <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			sbd_s[0] <= sb_div_in;
			for (int i = 1; i < vnu_pkg::DIV_STAGES; i++) begin
				sbd_s[i] <= sbd_s[i-1];
			end
			res_valid_q <= sbd_s[vnu_pkg::DIV_STAGES-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.unit_x      <= signed_unit(qx, sbd_s[vnu_pkg::DIV_STAGES-1].sign[2],
				sbd_s[vnu_pkg::DIV_STAGES-1].zero);
			res_q.unit_y      <= signed_unit(qy, sbd_s[vnu_pkg::DIV_STAGES-1].sign[1],
				sbd_s[vnu_pkg::DIV_STAGES-1].zero);
			res_q.unit_z      <= signed_unit(qz, sbd_s[vnu_pkg::DIV_STAGES-1].sign[0],
				sbd_s[vnu_pkg::DIV_STAGES-1].zero);
			res_q.magnitude   <= sbd_s[vnu_pkg::DIV_STAGES-1].zero ? 32'd0 :
				sbd_s[vnu_pkg::DIV_STAGES-1].mag;
			res_q.zero_vector <= sbd_s[vnu_pkg::DIV_STAGES-1].zero;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/vnu_sqrt.sv =====
// Pipelined integer square root of a 64-bit radicand, two result bits per stage.
// Depends on vnu_pkg.
module vnu_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	vnu_pkg::sqrt_acc_t acc_s [vnu_pkg::SQRT_STAGES];
	logic [63:0]        rad_s [vnu_pkg::SQRT_STAGES];
	vnu_pkg::sqrt_acc_t acc_d [vnu_pkg::SQRT_STAGES];
	logic [63:0]        rad_d [vnu_pkg::SQRT_STAGES];

	always_comb begin
		vnu_pkg::sqrt_acc_t a;
		logic [63:0]        r;
		for (int i = 0; i < vnu_pkg::SQRT_STAGES; i++) begin
			if (i == 0) begin
				a = '0;
				r = radicand;
			end else begin
				a = acc_s[i-1];
				r = rad_s[i-1];
			end
			for (int j = 0; j < vnu_pkg::SQRT_PER_STAGE; j++) begin
				if (i * vnu_pkg::SQRT_PER_STAGE + j < vnu_pkg::SQRT_STEPS) begin
					a = vnu_pkg::sqrt_step(a, r[63:62]);
					r = {r[61:0], 2'b00};
				end
			end
			acc_d[i] = a;
			rad_d[i] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < vnu_pkg::SQRT_STAGES; i++) begin
				acc_s[i] <= acc_d[i];
				rad_s[i] <= rad_d[i];
			end
		end
	end

	assign root = acc_s[vnu_pkg::SQRT_STAGES-1].root;

endmodule

// ===== hw/rtl/vnu_div.sv =====
// Pipelined restoring divider: floor(t * 2^30 / r) for t <= r, two quotient bits
// per stage. Depends on vnu_pkg.
module vnu_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] t,
	input  logic [31:0] divisor,
	output logic [30:0] quotient
);

	vnu_pkg::div_acc_t acc_s [vnu_pkg::DIV_STAGES];
	logic [30:0]       num_s [vnu_pkg::DIV_STAGES];
	logic [31:0]       dvs_s [vnu_pkg::DIV_STAGES];
	vnu_pkg::div_acc_t acc_d [vnu_pkg::DIV_STAGES];
	logic [30:0]       num_d [vnu_pkg::DIV_STAGES];
	logic [31:0]       dvs_d [vnu_pkg::DIV_STAGES];

	always_comb begin
		vnu_pkg::div_acc_t a;
		logic [30:0]       n;
		logic [31:0]       d;
		for (int i = 0; i < vnu_pkg::DIV_STAGES; i++) begin
			if (i == 0) begin
				a.rem = {1'b0, t[31:1]};
				a.quo = '0;
				n     = {t[0], 30'd0};
				d     = divisor;
			end else begin
				a = acc_s[i-1];
				n = num_s[i-1];
				d = dvs_s[i-1];
			end
			for (int j = 0; j < vnu_pkg::DIV_PER_STAGE; j++) begin
				if (i * vnu_pkg::DIV_PER_STAGE + j < vnu_pkg::DIV_STEPS) begin
					a = vnu_pkg::div_step(a, n[30], d);
					n = {n[29:0], 1'b0};
				end
			end
			acc_d[i] = a;
			num_d[i] = n;
			dvs_d[i] = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < vnu_pkg::DIV_STAGES; i++) begin
				acc_s[i] <= acc_d[i];
				num_s[i] <= num_d[i];
				dvs_s[i] <= dvs_d[i];
			end
		end
	end

	assign quotient = acc_s[vnu_pkg::DIV_STAGES-1].quo;

endmodule
